### sv/nge_pkg.sv
// ----------------------------------------------------------------------------
// nge_pkg
// Shared widths, command and status codes for the next-greater-element engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nge_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 16;

	localparam int CMD_W      = 2;
	localparam int VALUE_W    = 16;
	localparam int ANSWER_W   = 17;
	localparam int STATUS_W   = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

	// -1 in two's complement: no greater element
	localparam logic [ANSWER_W-1:0] ANSWER_NONE = '1;

endpackage

`default_nettype wire

### sv/nge_ram.sv
// ----------------------------------------------------------------------------
// nge_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nge_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/next_greater_element_engine.sv
// ----------------------------------------------------------------------------
// next_greater_element_engine
// Next-greater-element lookup built on a monotonic stack and a key table.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the command (clear, load, query), s_tdata the
// value. Load the list from its last element to its first; each load answers
// with the next greater-or-equal value (-1 if none) and records it. A
// query returns the recorded answer, or 0 with status "unknown" if the
// value was never loaded. Output stream: one transaction per input
// transaction, in order. Stack and key table each live in a one-port-read
// synchronous RAM. Steps per item: clear and other commands go straight to
// the commit step; a load pops stack entries while they are below the value,
// then scans the key table; a query only scans it. Each scan stops at the
// first matching key and reads one table entry per cycle.
// A new item is taken as soon as the previous result sits in the output
// register; a stalled receiver only holds the engine at the write-back step.
// Reset empties both stores (counts to zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module next_greater_element_engine
	import nge_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] value
	input  wire logic [CMD_W-1:0]      s_tuser,   // [1:0] cmd
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,   // [16:0] answer, rest zero
	output logic      [STATUS_W-1:0]   m_tuser    // [1:0] status
);

	localparam int KEY_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int TW    = ANSWER_W + KEY_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_POP    = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    val_q;
	logic [ANSWER_W-1:0] ans_q;
	logic [CW-1:0]       stack_cnt_q;
	logic [CW-1:0]       tbl_cnt_q;
	logic [CW-1:0]       scan_q;
	logic                srdv_s1;
	logic                trdv_s1;
	logic [AW-1:0]       tidx_s1;
	logic                found_q;
	logic [AW-1:0]       fidx_q;
	logic [ANSWER_W-1:0] fans_q;

	logic [KEY_W-1:0]    stack_rdata;
	logic [TW-1:0]       tbl_rdata;
	logic [KEY_W-1:0]    tbl_key;
	logic [ANSWER_W-1:0] tbl_ans;
	logic [CW-1:0]       cnt_m1;
	logic                out_free;
	logic                commit;
	logic                is_load;
	logic                stack_room;
	logic                tbl_room;
	logic                pop_hit;
	logic                tbl_hit;
	logic                scan_more;
	logic                stack_we;
	logic                tbl_we;
	logic [AW-1:0]       tbl_waddr;
	logic [ANSWER_W-1:0] res_ans;
	logic [STATUS_W-1:0] res_status;

	assign s_tready   = (state_q == ST_IDLE);
	assign out_free   = !m_tvalid || m_tready;
	assign commit     = (state_q == ST_COMMIT) && out_free;
	assign is_load    = (cmd_q == CMD_LOAD);
	assign cnt_m1     = stack_cnt_q - CW'(1);
	assign stack_room = stack_cnt_q < CW'(DEPTH);
	assign tbl_room   = tbl_cnt_q < CW'(DEPTH);
	assign pop_hit    = srdv_s1 && (stack_rdata < val_q);
	assign tbl_key    = tbl_rdata[KEY_W-1:0];
	assign tbl_ans    = tbl_rdata[KEY_W +: ANSWER_W];
	assign tbl_hit    = trdv_s1 && (tbl_key == val_q);
	assign scan_more  = scan_q < tbl_cnt_q;

	// Writes only happen in the commit cycle, so no read can overlap them
	assign stack_we  = commit && is_load && stack_room;
	assign tbl_we    = commit && is_load && (found_q || tbl_room);
	assign tbl_waddr = found_q ? fidx_q : tbl_cnt_q[AW-1:0];

	always_comb begin
		res_ans    = '0;
		res_status = STATUS_OK;
		case (cmd_q)
			CMD_LOAD: begin
				res_ans = ans_q;
				if ((!found_q && !tbl_room) || !stack_room) begin
					res_status = STATUS_FULL;
				end
			end
			CMD_QUERY: begin
				if (found_q) begin
					res_ans = fans_q;
				end else begin
					res_status = STATUS_UNKNOWN;
				end
			end
			default: begin
				res_ans    = '0;
				res_status = STATUS_OK;
			end
		endcase
	end

	nge_ram #(
		.WIDTH (KEY_W),
		.DEPTH (DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_cnt_q[AW-1:0]),
		.wdata (val_q),
		.raddr (cnt_m1[AW-1:0]),
		.rdata (stack_rdata)
	);

	nge_ram #(
		.WIDTH (TW),
		.DEPTH (DEPTH)
	) u_table_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata ({ans_q, val_q}),
		.raddr (scan_q[AW-1:0]),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stack_cnt_q <= '0;
			tbl_cnt_q   <= '0;
			srdv_s1     <= 1'b0;
			trdv_s1     <= 1'b0;
			found_q     <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						srdv_s1 <= 1'b0;
						trdv_s1 <= 1'b0;
						found_q <= 1'b0;
						scan_q  <= '0;
						if (s_tuser == CMD_LOAD) begin
							state_q <= ST_POP;
						end else if (s_tuser == CMD_QUERY) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_POP: begin
					// one stack read in flight at a time; a pop re-reads the new top
					if (srdv_s1) begin
						srdv_s1 <= 1'b0;
						if (pop_hit) begin
							stack_cnt_q <= cnt_m1;
						end else begin
							ans_q   <= ANSWER_W'(stack_rdata);
							state_q <= ST_SCAN;
						end
					end else if (stack_cnt_q == '0) begin
						ans_q   <= ANSWER_NONE;
						state_q <= ST_SCAN;
					end else begin
						srdv_s1 <= 1'b1;
					end
				end
				ST_SCAN: begin
					// read issued at scan_q, compared in the following cycle
					if (tbl_hit) begin
						found_q <= 1'b1;
						fidx_q  <= tidx_s1;
						fans_q  <= tbl_ans;
						trdv_s1 <= 1'b0;
						state_q <= ST_COMMIT;
					end else if (scan_more) begin
						trdv_s1 <= 1'b1;
						tidx_s1 <= scan_q[AW-1:0];
						scan_q  <= scan_q + CW'(1);
					end else begin
						trdv_s1 <= 1'b0;
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						m_tdata  <= OUT_DATA_W'(res_ans);
						m_tuser  <= res_status;
						state_q  <= ST_IDLE;
						if (cmd_q == CMD_CLEAR) begin
							stack_cnt_q <= '0;
							tbl_cnt_q   <= '0;
						end else if (is_load) begin
							if (stack_room) begin
								stack_cnt_q <= stack_cnt_q + CW'(1);
							end
							if (!found_q && tbl_room) begin
								tbl_cnt_q <= tbl_cnt_q + CW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_q <= s_tuser;
			val_q <= s_tdata[KEY_W-1:0];
		end
	end

endmodule

`default_nettype wire
